[rtl/core/ptgr_pkg.sv]
// Package for the planar tile glyph rasterizer.
// Holds the item codes, field widths and screen constants. No dependencies.
`default_nettype none

package ptgr_pkg;

  // Item codes on the request channel.
  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_RENDER = 1'b1
  } kind_e;

  localparam int unsigned SCREEN_SIZE   = 256;
  localparam int unsigned PAL_DEPTH     = 16;
  localparam int unsigned PAL_AW        = $clog2(PAL_DEPTH);
  localparam int unsigned COLOR_W       = 16;
  localparam int unsigned PLANE_W       = 64;
  localparam int unsigned POS_W         = 10;
  localparam int unsigned CLIP_W        = 8;
  localparam int unsigned ATTR_W        = 3;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned GLYPH_PIXELS  = 64;
  localparam int unsigned CNT_W         = $clog2(GLYPH_PIXELS);

  // Bit positions inside the attribute and clip fields.
  localparam int unsigned ATTR_HFLIP    = 0;
  localparam int unsigned ATTR_VFLIP    = 1;
  localparam int unsigned ATTR_ZERO_OK  = 2;
  localparam int unsigned CLIP_SIDE_BIT = 7;

endpackage

`default_nettype wire

[rtl/core/ptgr_req_if.sv]
// Request channel of the glyph rasterizer: palette loads and glyph renders.
// Depends on ptgr_pkg for the field widths.
`default_nettype none

interface ptgr_req_if import ptgr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [PAL_AW-1:0]         palette_slot;
  logic [COLOR_W-1:0]        palette_color;
  logic [PLANE_W-1:0]        plane_zero_rows;
  logic [PLANE_W-1:0]        plane_one_rows;
  logic [PLANE_W-1:0]        plane_two_rows;
  logic [PLANE_W-1:0]        plane_three_rows;
  logic signed [POS_W-1:0]   target_x;
  logic signed [POS_W-1:0]   target_y;
  logic [ATTR_W-1:0]         attributes;
  logic [CLIP_W-1:0]         row_clip;
  logic [CLIP_W-1:0]         column_clip;

  modport source (
    output valid, kind, palette_slot, palette_color, plane_zero_rows, plane_one_rows,
           plane_two_rows, plane_three_rows, target_x, target_y, attributes,
           row_clip, column_clip,
    input  ready
  );

  modport sink (
    input  valid, kind, palette_slot, palette_color, plane_zero_rows, plane_one_rows,
           plane_two_rows, plane_three_rows, target_x, target_y, attributes,
           row_clip, column_clip,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/ptgr_pix_if.sv]
// Pixel result channel of the glyph rasterizer.
// Depends on ptgr_pkg for the field widths.
`default_nettype none

interface ptgr_pix_if import ptgr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;
  logic [COLOR_W-1:0] color;
  logic               write;
  logic               last;

  modport source (
    output valid, pixel_x, pixel_y, color, write, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, color, write, last,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/ptgr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// A read at the address being written returns the old contents. No dependencies.
`default_nettype none

module ptgr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/planar_tile_glyph_rasterizer.sv]
// Top level of the planar tile glyph rasterizer: pixel walker, palette RAM, output stage.
// Depends on ptgr_pkg, ptgr_req_if, ptgr_pix_if and ptgr_ram.
//
//   Channel   Direction  Modport  Carries
//   req_i     in         sink     palette load or glyph render request
//   pix_o     out        source   one pixel of a glyph, row-major, last on pixel 64
//
// A render request gives 64 pixels, one per cycle while pix_o is not stalled; the rate is
// set by the pixel walker, which issues one palette RAM read per unstalled cycle.
// A palette load gives no pixel.
// The next request is taken in the cycle that issues the current glyph's last pixel.
// Acceptance sets busy_q, then the walker issues the first pixel; the palette read is registered.
// A stall on pix_o freezes the walker and the RAM read data; reset clears only control state.
`default_nettype none

module planar_tile_glyph_rasterizer import ptgr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ptgr_req_if.sink  req_i,
  ptgr_pix_if.source pix_o
);

  // Walker state.
  logic               busy_q, busy_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PLANE_W-1:0] plane0_q, plane1_q, plane2_q, plane3_q;
  logic [POS_W-1:0]   tx_q, ty_q;
  logic               hflip_q, vflip_q, zero_ok_q;
  logic [CLIP_W-1:0]  row_clip_q, col_clip_q;

  // Output stage.
  logic               pix_valid_q;
  logic [PIX_W-1:0]   pix_x_q, pix_y_q;
  logic               pix_write_q, pix_last_q;
  logic [COLOR_W-1:0] ram_rdata;

  logic advance, issue, req_fire, last_issue;
  logic is_render, is_load;

  assign advance    = !pix_valid_q || pix_o.ready;
  assign issue      = busy_q && advance;
  assign last_issue = issue && (cnt_q == {CNT_W{1'b1}});
  assign req_i.ready = !busy_q || last_issue;
  assign req_fire   = req_i.valid && req_i.ready;
  assign is_render  = (req_i.kind == KIND_RENDER);
  assign is_load    = (req_i.kind == KIND_LOAD);

  // Pixel address and colour index of the pixel being issued.
  logic [2:0]        row, col, src_row, src_bit;
  logic [CNT_W-1:0]  bit_idx;
  logic [PAL_AW-1:0] cidx;
  logic [POS_W:0]    sx, sy, row_line, col_line;
  logic              on_x, on_y, keep_x, keep_y, pix_write;

  always_comb begin
    row      = cnt_q[5:3];
    col      = cnt_q[2:0];
    src_row  = vflip_q ? ~row : row;
    src_bit  = hflip_q ? col : ~col;
    bit_idx  = {src_row, src_bit};
    cidx     = {plane3_q[bit_idx], plane2_q[bit_idx], plane1_q[bit_idx], plane0_q[bit_idx]};
    sx       = {tx_q[POS_W-1], tx_q} + {{(POS_W-2){1'b0}}, col};
    sy       = {ty_q[POS_W-1], ty_q} + {{(POS_W-2){1'b0}}, row};
    on_x     = !sx[POS_W] && (sx < (POS_W+1)'(SCREEN_SIZE));
    on_y     = !sy[POS_W] && (sy < (POS_W+1)'(SCREEN_SIZE));
    col_line = {{(POS_W-CLIP_W+1){1'b0}}, col_clip_q[CLIP_W-2:0], 1'b0};
    row_line = {{(POS_W-CLIP_W+1){1'b0}}, row_clip_q[CLIP_W-2:0], 1'b0};
    // Negative positions fail the screen test, so the unsigned compare is safe here.
    keep_x   = col_clip_q[CLIP_SIDE_BIT] ? (sx < col_line) : (sx >= col_line);
    keep_y   = row_clip_q[CLIP_SIDE_BIT] ? (sy < row_line) : (sy >= row_line);
    pix_write = on_x && on_y && keep_x && keep_y && ((cidx != '0) || zero_ok_q);
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (issue) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (last_issue) begin
        busy_d = 1'b0;
      end
    end
    if (req_fire && is_render) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      pix_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (advance) begin
        pix_valid_q <= issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire && is_render) begin
      plane0_q   <= req_i.plane_zero_rows;
      plane1_q   <= req_i.plane_one_rows;
      plane2_q   <= req_i.plane_two_rows;
      plane3_q   <= req_i.plane_three_rows;
      tx_q       <= req_i.target_x;
      ty_q       <= req_i.target_y;
      hflip_q    <= req_i.attributes[ATTR_HFLIP];
      vflip_q    <= req_i.attributes[ATTR_VFLIP];
      zero_ok_q  <= req_i.attributes[ATTR_ZERO_OK];
      row_clip_q <= req_i.row_clip;
      col_clip_q <= req_i.column_clip;
    end
    if (issue) begin
      pix_x_q     <= sx[PIX_W-1:0];
      pix_y_q     <= sy[PIX_W-1:0];
      pix_write_q <= pix_write;
      pix_last_q  <= (cnt_q == {CNT_W{1'b1}});
    end
  end

  // The palette read is issued with the pixel and lands with the output stage.
  ptgr_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (req_fire && is_load),
    .waddr_i (req_i.palette_slot),
    .wdata_i (req_i.palette_color),
    .re_i    (issue),
    .raddr_i (cidx),
    .rdata_o (ram_rdata)
  );

  assign pix_o.valid   = pix_valid_q;
  assign pix_o.pixel_x = pix_x_q;
  assign pix_o.pixel_y = pix_y_q;
  assign pix_o.write   = pix_write_q;
  assign pix_o.last    = pix_last_q;
  assign pix_o.color   = pix_write_q ? ram_rdata : '0;

  // A render request starts the walker at the first pixel.
  a_render_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && is_render) |=> (busy_q && cnt_q == '0))
    else $error("render request did not start the walker");

  // No request is taken while a glyph still has pixels to issue.
  a_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !last_issue) |-> !req_i.ready)
    else $error("request accepted in the middle of a glyph");

  // Issuing the 64th pixel puts a valid last pixel in the output stage.
  a_last_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_issue |=> (pix_valid_q && pix_last_q))
    else $error("last pixel missing after final issue");

  // The walker only goes idle after its final issue.
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(last_issue))
    else $error("walker stopped before the last pixel");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for planar_tile_glyph_rasterizer: palette loads and glyph renders.
// Depends on ptgr_pkg, ptgr_req_if, ptgr_pix_if and the rasterizer RTL.
`timescale 1ns / 1ps

module tb;
  import ptgr_pkg::*;

  typedef struct {
    kind_e                     kind;
    logic [PAL_AW-1:0]         slot;
    logic [COLOR_W-1:0]        shade;
    logic [3:0][PLANE_W-1:0]   planes;
    logic signed [POS_W-1:0]   tx;
    logic signed [POS_W-1:0]   ty;
    logic [ATTR_W-1:0]         attr;
    logic [CLIP_W-1:0]         row_clip;
    logic [CLIP_W-1:0]         col_clip;
  } glyph_req_t;

  typedef struct packed {
    logic [PIX_W-1:0]   x;
    logic [PIX_W-1:0]   y;
    logic [COLOR_W-1:0] color;
    logic               wr;
    logic               last;
  } pixel_t;

  logic clk_i;
  logic rst_ni;

  ptgr_req_if req_bus ();
  ptgr_pix_if pix_bus ();

  planar_tile_glyph_rasterizer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .pix_o  (pix_bus)
  );

  glyph_req_t         pending_reqs[$];
  glyph_req_t         req_on_bus;
  pixel_t             pixels_due[$];
  logic [COLOR_W-1:0] palette_mirror [PAL_DEPTH];
  int                 total_reqs;
  int                 req_sent;
  int                 req_accepts;
  int                 pixels_seen;
  int                 mismatches;
  int                 send_idle;
  int                 recv_hold;
  bit                 long_hold_done;

  // Neither side idles for the last stretch of requests.
  wire quiet_tail = (req_accepts + 50 >= total_reqs);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic bit clip_passes(int pos, logic [CLIP_W-1:0] clip);
    int line;
    line = int'(clip[6:0]) * 2;
    return clip[CLIP_SIDE_BIT] ? (pos < line) : (pos >= line);
  endfunction

  function automatic bit on_screen(int pos);
    return pos >= 0 && pos < int'(SCREEN_SIZE);
  endfunction

  // Expands one accepted render request into its 64 pixels, row-major.
  function automatic void rasterize_glyph(glyph_req_t g);
    int     sx;
    int     sy;
    int     src_row;
    int     src_bit;
    bit     row_ok;
    logic [3:0] idx;
    pixel_t px;
    for (int r = 0; r < 8; r++) begin
      sy      = g.ty + r;
      src_row = g.attr[ATTR_VFLIP] ? 7 - r : r;
      row_ok  = on_screen(sy) && clip_passes(sy, g.row_clip);
      for (int c = 0; c < 8; c++) begin
        sx      = g.tx + c;
        src_bit = g.attr[ATTR_HFLIP] ? c : 7 - c;
        for (int p = 0; p < 4; p++) begin
          idx[p] = g.planes[p][8 * src_row + src_bit];
        end
        px.x     = sx[PIX_W-1:0];
        px.y     = sy[PIX_W-1:0];
        px.wr    = row_ok && on_screen(sx) && clip_passes(sx, g.col_clip) &&
                   (idx != 4'd0 || g.attr[ATTR_ZERO_OK]);
        px.color = px.wr ? palette_mirror[idx] : '0;
        px.last  = (r == 7 && c == 7);
        pixels_due.push_back(px);
      end
    end
  endfunction

  function automatic logic [PLANE_W-1:0] rand_plane();
    return {$urandom, $urandom};
  endfunction

  function automatic glyph_req_t load_req(logic [PAL_AW-1:0] slot, logic [COLOR_W-1:0] shade);
    glyph_req_t g;
    g.kind     = KIND_LOAD;
    g.slot     = slot;
    g.shade    = shade;
    // The render fields carry noise on a load.
    for (int p = 0; p < 4; p++) g.planes[p] = rand_plane();
    g.tx       = POS_W'($urandom);
    g.ty       = POS_W'($urandom);
    g.attr     = ATTR_W'($urandom);
    g.row_clip = CLIP_W'($urandom);
    g.col_clip = CLIP_W'($urandom);
    return g;
  endfunction

  function automatic glyph_req_t render_req(logic [3:0][PLANE_W-1:0] planes, int tx, int ty,
                                            logic [ATTR_W-1:0] attr,
                                            logic [CLIP_W-1:0] row_clip,
                                            logic [CLIP_W-1:0] col_clip);
    glyph_req_t g;
    g.kind     = KIND_RENDER;
    g.slot     = PAL_AW'($urandom);
    g.shade    = COLOR_W'($urandom);
    g.planes   = planes;
    g.tx       = POS_W'(tx);
    g.ty       = POS_W'(ty);
    g.attr     = attr;
    g.row_clip = row_clip;
    g.col_clip = col_clip;
    return g;
  endfunction

  // Mostly on screen, with a fair share near the edges and across the whole range.
  function automatic int pick_pos();
    case ($urandom_range(0, 9))
      0, 1:    return int'($urandom_range(0, 24)) - 12;
      2, 3:    return int'($urandom_range(0, 19)) + 244;
      4:       return int'($urandom_range(0, 1023)) - 512;
      default: return int'($urandom_range(0, 248));
    endcase
  endfunction

  function automatic logic [CLIP_W-1:0] pick_clip();
    return ($urandom_range(0, 1) == 0) ? 8'h00 : CLIP_W'($urandom);
  endfunction

  function automatic glyph_req_t random_glyph();
    logic [3:0][PLANE_W-1:0] planes;
    bit sparse;
    sparse = ($urandom_range(0, 2) == 0);
    for (int p = 0; p < 4; p++) begin
      planes[p] = sparse ? rand_plane() & rand_plane() & rand_plane() : rand_plane();
    end
    return render_req(planes, pick_pos(), pick_pos(), ATTR_W'($urandom), pick_clip(),
                      pick_clip());
  endfunction

  // Request driver: a request stays on the bus until it has been accepted.
  always @(negedge clk_i) begin
    if (rst_ni && req_sent == req_accepts) begin
      if (send_idle > 0) begin
        req_bus.valid <= 1'b0;
        send_idle = send_idle - 1;
      end else if (pending_reqs.size() == 0) begin
        req_bus.valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        req_bus.valid <= 1'b0;
        send_idle = $urandom_range(0, 7);
      end else begin
        req_on_bus = pending_reqs.pop_front();
        req_bus.valid            <= 1'b1;
        req_bus.kind             <= req_on_bus.kind;
        req_bus.palette_slot     <= req_on_bus.slot;
        req_bus.palette_color    <= req_on_bus.shade;
        req_bus.plane_zero_rows  <= req_on_bus.planes[0];
        req_bus.plane_one_rows   <= req_on_bus.planes[1];
        req_bus.plane_two_rows   <= req_on_bus.planes[2];
        req_bus.plane_three_rows <= req_on_bus.planes[3];
        req_bus.target_x         <= req_on_bus.tx;
        req_bus.target_y         <= req_on_bus.ty;
        req_bus.attributes       <= req_on_bus.attr;
        req_bus.row_clip         <= req_on_bus.row_clip;
        req_bus.column_clip      <= req_on_bus.col_clip;
        req_sent = req_sent + 1;
      end
    end
  end

  // Pixel receiver: short random stalls, plus one long hold-off so the block backs up.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_hold > 0) begin
        pix_bus.ready <= 1'b0;
        recv_hold = recv_hold - 1;
      end else if (!long_hold_done && pixels_seen >= 300) begin
        pix_bus.ready <= 1'b0;
        long_hold_done = 1'b1;
        recv_hold = 400;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        pix_bus.ready <= 1'b0;
        recv_hold = $urandom_range(0, 7);
      end else begin
        pix_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t want;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        req_accepts <= req_accepts + 1;
        if (req_on_bus.kind == KIND_LOAD) begin
          palette_mirror[req_on_bus.slot] = req_on_bus.shade;
        end else begin
          rasterize_glyph(req_on_bus);
        end
      end
      if (pix_bus.valid && pix_bus.ready) begin
        got.x     = pix_bus.pixel_x;
        got.y     = pix_bus.pixel_y;
        got.color = pix_bus.color;
        got.wr    = pix_bus.write;
        got.last  = pix_bus.last;
        pixels_seen = pixels_seen + 1;
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected pixel x=%0d y=%0d color=%h write=%b last=%b",
                   $time, got.x, got.y, got.color, got.wr, got.last);
          mismatches = mismatches + 1;
        end else begin
          want = pixels_due.pop_front();
          if (got !== want) begin
            $display("%0t: pixel mismatch expected x=%0d y=%0d color=%h write=%b last=%b",
                     $time, want.x, want.y, want.color, want.wr, want.last);
            $display("%0t:                  actual x=%0d y=%0d color=%h write=%b last=%b",
                     $time, got.x, got.y, got.color, got.wr, got.last);
            mismatches = mismatches + 1;
          end
        end
      end
    end
  end

  initial begin
    logic [3:0][PLANE_W-1:0] ones;
    logic [3:0][PLANE_W-1:0] zeros;
    logic [3:0][PLANE_W-1:0] mixed;
    logic [3:0][PLANE_W-1:0] diag;
    rst_ni                   = 1'b0;
    req_bus.valid            = 1'b0;
    req_bus.kind             = KIND_LOAD;
    req_bus.palette_slot     = '0;
    req_bus.palette_color    = '0;
    req_bus.plane_zero_rows  = '0;
    req_bus.plane_one_rows   = '0;
    req_bus.plane_two_rows   = '0;
    req_bus.plane_three_rows = '0;
    req_bus.target_x         = '0;
    req_bus.target_y         = '0;
    req_bus.attributes       = '0;
    req_bus.row_clip         = '0;
    req_bus.column_clip      = '0;
    pix_bus.ready            = 1'b0;
    req_sent       = 0;
    req_accepts    = 0;
    pixels_seen    = 0;
    mismatches     = 0;
    send_idle      = 0;
    recv_hold      = 0;
    long_hold_done = 1'b0;
    total_reqs     = 0;

    // Every palette entry is written before any render, so no render reads an unset entry.
    for (int s = 0; s < PAL_DEPTH; s++) begin
      case (s)
        0:       pending_reqs.push_back(load_req(PAL_AW'(s), 16'h0000));
        1:       pending_reqs.push_back(load_req(PAL_AW'(s), 16'hFFFF));
        2:       pending_reqs.push_back(load_req(PAL_AW'(s), 16'hAAAA));
        3:       pending_reqs.push_back(load_req(PAL_AW'(s), 16'h5555));
        default: pending_reqs.push_back(load_req(PAL_AW'(s), COLOR_W'($urandom)));
      endcase
    end

    ones  = '1;
    zeros = '0;
    for (int p = 0; p < 4; p++) mixed[p] = rand_plane();
    diag[0] = 64'h0102_0408_1020_4080;
    diag[1] = 64'h0303_0C0C_3030_C0C0;
    diag[2] = 64'h0F0F_0F0F_F0F0_F0F0;
    diag[3] = 64'h00FF_00FF_00FF_00FF;

    // Plain glyph at the origin with no clipping.
    pending_reqs.push_back(render_req(mixed, 0, 0, 3'b000, 8'h00, 8'h00));
    // Wholly off screen, at both ends of the position range.
    pending_reqs.push_back(render_req(ones, 511, 511, 3'b011, 8'h00, 8'h00));
    pending_reqs.push_back(render_req(ones, -512, -512, 3'b111, 8'hFF, 8'hFF));
    // Straddles the left and bottom screen edges, both flips, draw-zero.
    pending_reqs.push_back(render_req(diag, -4, 252, 3'b111, 8'h00, 8'h00));
    // Keep-below clip lines cut through the glyph on both axes.
    pending_reqs.push_back(render_req(mixed, 250, 6, 3'b001, 8'h85, 8'hFF));
    // Keep-at-or-after clip lines cut through the glyph, then keep-below lines near the far corner.
    pending_reqs.push_back(render_req(diag, 4, 250, 3'b010, 8'h7F, 8'h04));
    pending_reqs.push_back(render_req(diag, 248, 248, 3'b001, 8'hFF, 8'hFF));
    // Only colour index zero, not drawn.
    pending_reqs.push_back(render_req(zeros, 100, 100, 3'b000, 8'h00, 8'h00));
    // A keep-below line at zero removes every row.
    pending_reqs.push_back(render_req(ones, 40, 40, 3'b010, 8'h80, 8'h00));

    for (int n = 0; n < 405; n++) begin
      if ($urandom_range(0, 99) < 15) begin
        pending_reqs.push_back(load_req(PAL_AW'($urandom), COLOR_W'($urandom)));
      end else begin
        pending_reqs.push_back(random_glyph());
      end
    end
    total_reqs = pending_reqs.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (req_accepts == total_reqs);
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
